[rtl/ocx_pkg.sv]
// shared constants and types for the order crossover block
// no dependencies; imported by the interfaces and the top level
package ocx_pkg;

	// field widths
	localparam int CITY_W     = 5;
	localparam int POS_W      = 5;
	localparam int DRAW_W     = 16;
	localparam int CNT_CFG_W  = 6;
	localparam int THR_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// number of distinct city identifiers and most positions of one run
	localparam int CITY_IDS   = 1 << CITY_W;
	localparam int RESULT_CAP = 32;

	// default capacity of the parent stores
	localparam int MAX_CITIES_DEF = 32;

	// commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CITY_COUNT      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CROSS_THRESHOLD = 1'b1;

	// register reset values
	localparam logic [CNT_CFG_W-1:0] CITY_COUNT_RST = 6'd32;
	localparam logic [THR_W-1:0]     THRESHOLD_RST  = 16'hFFFF;

	// one result item
	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [CITY_W-1:0] first_son;
		logic [CITY_W-1:0] second_son;
		logic              crossed;
		logic              last;
	} ocx_res_t;

endpackage

[rtl/ocx_ifs.sv]
// channel interfaces of the order crossover block: items, results, config writes
// depends on ocx_pkg for the field widths
interface ocx_in_if;
	import ocx_pkg::*;

	logic                valid;
	logic                ready;
	logic                command;
	logic [POS_W-1:0]    position;
	logic [CITY_W-1:0]   first_parent_city;
	logic [CITY_W-1:0]   second_parent_city;
	logic [DRAW_W-1:0]   random_draw;
	logic [POS_W-1:0]    cut_point;

	modport source (output valid, command, position, first_parent_city,
		second_parent_city, random_draw, cut_point, input ready);
	modport sink (input valid, command, position, first_parent_city,
		second_parent_city, random_draw, cut_point, output ready);
endinterface

interface ocx_out_if;
	import ocx_pkg::*;

	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  out_position;
	logic [CITY_W-1:0] first_son_city;
	logic [CITY_W-1:0] second_son_city;
	logic              crossed;
	logic              last;

	modport source (output valid, out_position, first_son_city, second_son_city,
		crossed, last, input ready);
	modport sink (input valid, out_position, first_son_city, second_son_city,
		crossed, last, output ready);
endinterface

interface ocx_cfg_if;
	import ocx_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/ocx_ram.sv]
// generic simple dual port ram: one write port, one registered read port
// no dependencies
module ocx_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/order_crossover_permutation.sv]
// one-point order crossover of two city permutations held in block rams
// depends on ocx_pkg, the channel interfaces in ocx_ifs and ocx_ram
//
// Usage: a load transaction on items (command 0) writes one position of both
// parents and returns no result. A run transaction (command 1) compares
// random_draw with cross_threshold and then emits n results on the results
// channel, n being city_count clamped to 2 .. min(MAX_CITIES, 32), positions
// 0 to n-1, last set on the final one. Registers are written through cfg
// (index 0 city_count, 1 cross_threshold); the user must do so only while the
// block is idle, which the block does not enforce; cfg is always ready.
// Sequence: a crossover run first scans the parent rams from the cut to n-1
// to build two city bitmaps, then scans all n positions to write the two
// tails into the tail rams. The output pass then issues one position read per
// cycle while a result slot is free; results follow one per cycle while
// results is ready. A copy run goes straight to the output pass. Each ram has
// a single read port, so the passes run one after another. New items are
// taken once the last read of a run is issued. Reset clears control state and
// the registers to their defaults; parent ram contents are undefined until
// loaded. When results stalls, up to two results wait in an output and a skid
// register; a read is issued only if its result has a slot, so none is dropped.
module order_crossover_permutation #(
	parameter int MAX_CITIES = ocx_pkg::MAX_CITIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ocx_in_if.sink    items,
	ocx_out_if.source results,
	ocx_cfg_if.sink   cfg
);
	import ocx_pkg::*;

	localparam int AW  = $clog2(MAX_CITIES);
	localparam int LIM = (MAX_CITIES < RESULT_CAP) ? MAX_CITIES : RESULT_CAP;
	localparam int TCW = $clog2(MAX_CITIES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MASK,
		ST_TAIL,
		ST_WAIT,
		ST_OUT
	} state_t;

	// configuration registers
	logic [CNT_CFG_W-1:0] city_count_q;
	logic [THR_W-1:0]     threshold_q;

	// run control
	state_t               state_q;
	logic [CNT_CFG_W-1:0] n_q;
	logic [POS_W-1:0]     cut_q;
	logic                 crossed_q;
	logic [POS_W-1:0]     idx_q;
	logic [CITY_IDS-1:0]  mask1_q;
	logic [CITY_IDS-1:0]  mask2_q;
	logic [TCW-1:0]       cnt1_q;
	logic [TCW-1:0]       cnt2_q;
	logic                 scan_s1;
	logic                 tail_s1;

	// output read stage
	logic                 out_s1;
	logic [POS_W-1:0]     pos_s1;
	logic                 use_par_s1;
	logic                 zero1_s1;
	logic                 zero2_s1;
	logic                 crossed_s1;
	logic                 last_s1;

	// output register and skid
	ocx_res_t             res_q;
	ocx_res_t             skid_q;
	logic                 res_valid_q;
	logic                 skid_valid_q;

	// ram ports
	logic [CITY_W-1:0]    p1_rd;
	logic [CITY_W-1:0]    p2_rd;
	logic [CITY_W-1:0]    t1_rd;
	logic [CITY_W-1:0]    t2_rd;
	logic                 par_we;
	logic                 t1_we;
	logic                 t2_we;

	// combinational helpers
	logic                 acc;
	logic                 pop;
	logic                 can_issue;
	logic                 issue;
	logic [1:0]           occ;
	logic [CNT_CFG_W-1:0] n_c;
	logic [CNT_CFG_W-1:0] nm1_c;
	logic [POS_W-1:0]     cut_c;
	logic                 crossed_c;
	logic                 idx_last;
	logic [POS_W-1:0]     k_c;
	logic                 use_par_c;
	ocx_res_t             res_new;

	// handshakes
	assign items.ready = (state_q == ST_IDLE);
	assign acc         = items.valid && items.ready;
	assign cfg.ready   = 1'b1;
	assign pop         = res_valid_q && results.ready;

	// cities in use, clamped cut and crossover decision
	always_comb begin
		if (city_count_q > CNT_CFG_W'(LIM)) begin
			n_c = CNT_CFG_W'(LIM);
		end else if (city_count_q < CNT_CFG_W'(2)) begin
			n_c = CNT_CFG_W'(2);
		end else begin
			n_c = city_count_q;
		end
		nm1_c = n_c - CNT_CFG_W'(1);
		if (items.cut_point == '0) begin
			cut_c = POS_W'(1);
		end else if ({1'b0, items.cut_point} > nm1_c) begin
			cut_c = nm1_c[POS_W-1:0];
		end else begin
			cut_c = items.cut_point;
		end
		crossed_c = (items.random_draw <= threshold_q);
	end

	assign idx_last  = ({1'b0, idx_q} == n_q - CNT_CFG_W'(1));
	assign k_c       = idx_q - cut_q;
	assign use_par_c = !crossed_q || (idx_q < cut_q);

	// issue a result read only if it has a slot when its data returns
	assign occ       = 2'(res_valid_q) + 2'(skid_valid_q) + 2'(out_s1) - 2'(pop);
	assign can_issue = (occ <= 2'd1);
	assign issue     = (state_q == ST_OUT) && can_issue;

	// parent and tail rams
	assign par_we = acc && (items.command == CMD_LOAD) && (32'(items.position) < MAX_CITIES);
	assign t1_we  = tail_s1 && mask1_q[p2_rd];
	assign t2_we  = tail_s1 && mask2_q[p1_rd];

	ocx_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_parent1 (
		.clk   (clk),
		.we    (par_we),
		.waddr (AW'(items.position)),
		.wdata (items.first_parent_city),
		.raddr (AW'(idx_q)),
		.rdata (p1_rd)
	);

	ocx_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_parent2 (
		.clk   (clk),
		.we    (par_we),
		.waddr (AW'(items.position)),
		.wdata (items.second_parent_city),
		.raddr (AW'(idx_q)),
		.rdata (p2_rd)
	);

	ocx_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_tail1 (
		.clk   (clk),
		.we    (t1_we),
		.waddr (AW'(cnt1_q)),
		.wdata (p2_rd),
		.raddr (AW'(k_c)),
		.rdata (t1_rd)
	);

	ocx_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_tail2 (
		.clk   (clk),
		.we    (t2_we),
		.waddr (AW'(cnt2_q)),
		.wdata (p1_rd),
		.raddr (AW'(k_c)),
		.rdata (t2_rd)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= CITY_COUNT_RST;
			threshold_q  <= THRESHOLD_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_CITY_COUNT:      city_count_q <= cfg.data[CNT_CFG_W-1:0];
				REG_CROSS_THRESHOLD: threshold_q  <= cfg.data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// run sequencer: bitmap pass, tail pass, output pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			n_q        <= '0;
			cut_q      <= '0;
			crossed_q  <= 1'b0;
			idx_q      <= '0;
			mask1_q    <= '0;
			mask2_q    <= '0;
			cnt1_q     <= '0;
			cnt2_q     <= '0;
			scan_s1    <= 1'b0;
			tail_s1    <= 1'b0;
			out_s1     <= 1'b0;
			pos_s1     <= '0;
			use_par_s1 <= 1'b0;
			zero1_s1   <= 1'b0;
			zero2_s1   <= 1'b0;
			crossed_s1 <= 1'b0;
			last_s1    <= 1'b0;
		end else begin
			scan_s1 <= 1'b0;
			tail_s1 <= 1'b0;
			out_s1  <= issue;

			// bitmap of cities found in each parent's tail
			if (scan_s1) begin
				mask1_q[p1_rd] <= 1'b1;
				mask2_q[p2_rd] <= 1'b1;
			end

			// append matching cities to the tails
			if (t1_we) begin
				cnt1_q <= cnt1_q + TCW'(1);
			end
			if (t2_we) begin
				cnt2_q <= cnt2_q + TCW'(1);
			end

			// payload of the result read
			if (issue) begin
				pos_s1     <= idx_q;
				use_par_s1 <= use_par_c;
				zero1_s1   <= (32'(k_c) >= 32'(cnt1_q));
				zero2_s1   <= (32'(k_c) >= 32'(cnt2_q));
				crossed_s1 <= crossed_q;
				last_s1    <= idx_last;
			end

			case (state_q)
				ST_IDLE: begin
					if (acc && (items.command == CMD_RUN)) begin
						n_q       <= n_c;
						cut_q     <= cut_c;
						crossed_q <= crossed_c;
						mask1_q   <= '0;
						mask2_q   <= '0;
						cnt1_q    <= '0;
						cnt2_q    <= '0;
						if (crossed_c) begin
							idx_q   <= cut_c;
							state_q <= ST_MASK;
						end else begin
							idx_q   <= '0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_MASK: begin
					scan_s1 <= 1'b1;
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= ST_TAIL;
					end else begin
						idx_q <= idx_q + POS_W'(1);
					end
				end
				ST_TAIL: begin
					tail_s1 <= 1'b1;
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= ST_WAIT;
					end else begin
						idx_q <= idx_q + POS_W'(1);
					end
				end
				ST_WAIT: begin
					// last tail write lands before the output pass reads
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (issue) begin
						if (idx_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + POS_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// son cities from parent or tail read data
	always_comb begin
		res_new.position   = pos_s1;
		res_new.crossed    = crossed_s1;
		res_new.last       = last_s1;
		if (use_par_s1) begin
			res_new.first_son  = p1_rd;
			res_new.second_son = p2_rd;
		end else begin
			res_new.first_son  = zero1_s1 ? '0 : t1_rd;
			res_new.second_son = zero2_s1 ? '0 : t2_rd;
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_s1 && pop) begin
				if (skid_valid_q) begin
					res_q  <= skid_q;
					skid_q <= res_new;
				end else begin
					res_q <= res_new;
				end
			end else if (out_s1) begin
				if (!res_valid_q) begin
					res_q       <= res_new;
					res_valid_q <= 1'b1;
				end else begin
					skid_q       <= res_new;
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_valid_q) begin
					res_q        <= skid_q;
					skid_valid_q <= 1'b0;
				end else begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	assign results.valid           = res_valid_q;
	assign results.out_position    = res_q.position;
	assign results.first_son_city  = res_q.first_son;
	assign results.second_son_city = res_q.second_son;
	assign results.crossed         = res_q.crossed;
	assign results.last            = res_q.last;

endmodule
